### hw/rtl/dspe_pkg.sv
package dspe_pkg;

	// opcode field of an input item
	localparam logic OPC_WRITE = 1'b0;
	localparam logic OPC_RUN   = 1'b1;

	// distance code for a vertex not reached
	localparam logic [15:0] UNREACHED = 16'hFFFF;

	// vertex_count after reset
	localparam logic [6:0] VCOUNT_RESET = 7'd64;

	typedef struct packed {
		logic        opcode;
		logic [5:0]  from_vertex;
		logic [5:0]  to_vertex;
		logic [7:0]  edge_weight;
	} dspe_item_t;

	typedef struct packed {
		logic [5:0]  vertex_index;
		logic        reachable;
		logic [15:0] distance;
		logic [5:0]  predecessor;
		logic        last;
	} dspe_result_t;

	// one entry of the per-vertex search memory
	typedef struct packed {
		logic        settled;
		logic [5:0]  prev;
		logic [15:0] cost;
	} dspe_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_SETTLE,
		ST_RELAX,
		ST_RELAX_END,
		ST_OUT,
		ST_OUT_END
	} dspe_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_WRITE,
		OP_LOAD,
		OP_INIT,
		OP_SCAN,
		OP_SETTLE,
		OP_RELAX,
		OP_OUT
	} dspe_op_t;

	typedef struct packed {
		dspe_op_t   op;
		logic [5:0] row;
		logic [5:0] col;
	} dspe_cmd_t;

	typedef struct packed {
		logic       found;
		logic [5:0] n_last;
	} dspe_status_t;

endpackage

### hw/rtl/dspe_ctrl.sv
module dspe_ctrl import dspe_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         opcode,
	input  dspe_status_t status,
	output logic         busy,
	output dspe_cmd_t    cmd
);

	localparam logic [5:0] LastIdx = 6'(MAX_VERTICES - 1);

	dspe_state_t state_q, state_d;
	logic [5:0]  cnt_q;
	logic [5:0]  row_q;
	logic        cnt_wrap;

	assign cnt_wrap = (cnt_q == status.n_last);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (cnt_q == LastIdx && row_q == LastIdx) state_d = ST_IDLE;
			ST_IDLE:      if (start && opcode == OPC_RUN) state_d = ST_INIT;
			ST_INIT:      if (cnt_wrap) state_d = ST_SCAN;
			ST_SCAN:      if (cnt_wrap) state_d = ST_SCAN_END;
			ST_SCAN_END:  state_d = ST_PICK;
			ST_PICK:      state_d = status.found ? ST_SETTLE : ST_OUT;
			ST_SETTLE:    state_d = ST_RELAX;
			ST_RELAX:     if (cnt_wrap) state_d = ST_RELAX_END;
			ST_RELAX_END: state_d = ST_SCAN;
			ST_OUT:       if (cnt_wrap) state_d = ST_OUT_END;
			ST_OUT_END:   state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// state and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LastIdx) begin
						cnt_q <= '0;
						row_q <= row_q + 6'd1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_INIT, ST_SCAN, ST_RELAX, ST_OUT: begin
					cnt_q <= cnt_wrap ? 6'd0 : cnt_q + 6'd1;
				end
				ST_IDLE: cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// datapath commands
	always_comb begin
		busy    = (state_q != ST_IDLE);
		cmd.op  = OP_NONE;
		cmd.row = row_q;
		cmd.col = cnt_q;
		unique case (state_q)
			ST_CLEAR:  cmd.op = OP_CLEAR;
			ST_IDLE: begin
				if (start) cmd.op = (opcode == OPC_WRITE) ? OP_WRITE : OP_LOAD;
			end
			ST_INIT:   cmd.op = OP_INIT;
			ST_SCAN:   cmd.op = OP_SCAN;
			ST_SETTLE: cmd.op = OP_SETTLE;
			ST_RELAX:  cmd.op = OP_RELAX;
			ST_OUT:    cmd.op = OP_OUT;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule

### hw/rtl/dspe_datapath.sv
module dspe_datapath import dspe_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  dspe_cmd_t    cmd,
	input  dspe_item_t   item,
	input  logic         cfg_valid,
	input  logic [6:0]   cfg_data,
	output dspe_status_t status,
	output logic         result_valid,
	output dspe_result_t result
);

	localparam int VB       = $clog2(MAX_VERTICES);
	localparam int Depth    = 1 << VB;
	localparam int MatDepth = 1 << (2 * VB);

	logic [WEIGHT_BITS-1:0] mat_q [MatDepth];
	dspe_word_t             word_q [Depth];

	logic [6:0]             vc_q;
	logic [5:0]             n_last;
	logic [5:0]             src_q;

	dspe_op_t               op_s1;
	logic [5:0]             idx_s1;
	dspe_word_t             word_s1;
	logic [WEIGHT_BITS-1:0] mat_s1;

	logic                   found_q;
	logic [15:0]            best_q;
	logic [VB-1:0]          pick_q;
	dspe_word_t             pick_word_q;

	logic [15:0]            weight_wide;
	logic [WEIGHT_BITS-1:0] weight_cut;
	logic                   wr_in_range;
	logic [15:0]            scan_least;
	logic                   scan_take;
	logic [16:0]            sum;
	logic                   improve;
	logic                   wr_en;
	logic [VB-1:0]          wr_addr;
	dspe_word_t             wr_word;

	// vertex count register, clamped into 1..MAX_VERTICES on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_q <= VCOUNT_RESET;
		else if (cfg_valid) vc_q <= cfg_data;
	end

	always_comb begin
		if (vc_q == 7'd0) n_last = 6'd0;
		else if (vc_q > 7'(MAX_VERTICES)) n_last = 6'(MAX_VERTICES - 1);
		else n_last = 6'(vc_q - 7'd1);
	end

	// latch the source of a run
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) src_q <= item.from_vertex;
	end

	// edge write: drop out-of-range vertices, cut weight to matrix width
	assign weight_wide = 16'(item.edge_weight);
	assign weight_cut  = weight_wide[WEIGHT_BITS-1:0];
	assign wr_in_range = (7'(item.from_vertex) < 7'(MAX_VERTICES)) &&
	                     (7'(item.to_vertex) < 7'(MAX_VERTICES));

	// weight matrix: clear sweep, edge writes, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLEAR) begin
			mat_q[{cmd.row[VB-1:0], cmd.col[VB-1:0]}] <= '0;
		end else if (cmd.op == OP_WRITE && wr_in_range) begin
			mat_q[{item.from_vertex[VB-1:0], item.to_vertex[VB-1:0]}] <= weight_cut;
		end
		mat_s1 <= mat_q[{pick_q, cmd.col[VB-1:0]}];
	end

	// stage tag for the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) op_s1 <= OP_NONE;
		else op_s1 <= cmd.op;
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.col;
	end

	// minimum search over unsettled vertices, lowest index wins ties
	assign scan_least = (idx_s1 == 6'd0) ? UNREACHED : best_q;
	assign scan_take  = !word_s1.settled && (word_s1.cost < scan_least);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (op_s1 == OP_SCAN) begin
			if (scan_take) found_q <= 1'b1;
			else if (idx_s1 == 6'd0) found_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_s1 == OP_SCAN) begin
			if (scan_take) begin
				best_q      <= word_s1.cost;
				pick_q      <= idx_s1[VB-1:0];
				pick_word_q <= word_s1;
			end else if (idx_s1 == 6'd0) begin
				best_q <= UNREACHED;
			end
		end
	end

	// relax edges out of the picked vertex
	assign sum     = 17'(pick_word_q.cost) + 17'(mat_s1);
	assign improve = (op_s1 == OP_RELAX) && !word_s1.settled && (mat_s1 != '0) &&
	                 (sum < 17'(UNREACHED)) && (sum[15:0] < word_s1.cost);

	// search memory write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmd.col[VB-1:0];
		wr_word = '{settled: 1'b0, prev: 6'd0, cost: UNREACHED};
		priority if (cmd.op == OP_INIT) begin
			wr_en = 1'b1;
			if (cmd.col == src_q) wr_word = '{settled: 1'b0, prev: src_q, cost: 16'd0};
		end else if (cmd.op == OP_SETTLE) begin
			wr_en   = 1'b1;
			wr_addr = pick_q;
			wr_word = '{settled: 1'b1, prev: pick_word_q.prev, cost: pick_word_q.cost};
		end else if (improve) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1[VB-1:0];
			wr_word = '{settled: 1'b0, prev: 6'(pick_q), cost: sum[15:0]};
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) word_q[wr_addr] <= wr_word;
		word_s1 <= word_q[cmd.col[VB-1:0]];
	end

	assign status.found  = found_q;
	assign status.n_last = n_last;

	// result item from the registered read
	assign result_valid        = (op_s1 == OP_OUT);
	assign result.vertex_index = idx_s1;
	assign result.reachable    = word_s1.settled;
	assign result.distance     = word_s1.settled ? word_s1.cost : UNREACHED;
	assign result.predecessor  = word_s1.settled ? word_s1.prev : 6'd0;
	assign result.last         = (idx_s1 == n_last);

endmodule

### hw/rtl/dense_shortest_path_engine_top.sv
// Single-source shortest paths (Dijkstra, dense O(V^2)) over a weight matrix
// of MAX_VERTICES x MAX_VERTICES entries, zero meaning no edge. After reset
// the block clears the matrix one entry per cycle, with busy high;
// configuration writes are taken at any time. A run item keeps busy high
// until its results are out: each settled vertex costs one scan of the
// search memory for the minimum and one pass reading its matrix row, one
// entry per cycle through the single read port. The results, one per
// vertex in use, come on consecutive cycles, each marked by result_valid
// for one cycle, with no way to hold them off; the receiver must take
// every one.
module dense_shortest_path_engine_top import dspe_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  dspe_item_t   item,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [6:0]   cfg_data,
	output logic         result_valid,
	output dspe_result_t result
);

	dspe_cmd_t    cmd;
	dspe_status_t status;

	// the count register takes a write every cycle
	assign cfg_ready = 1'b1;

	dspe_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	dspe_datapath #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### hw/rtl/dspe_checker.sv
module dspe_checker import dspe_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input dspe_item_t   item,
	input logic         result_valid,
	input dspe_result_t result
);

	// results appear only inside a run
	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result item outside a run");

	// results of one run come on consecutive cycles
	a_results_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap in result items");

	// vertices come in ascending order
	a_index_ascends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=>
			result.vertex_index == 6'($past(result.vertex_index) + 6'd1))
		else $error("result vertex index out of order");

	// nothing follows the last result of a run
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result item after last");

	// a write item causes no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.opcode == OPC_WRITE |=> !result_valid)
		else $error("result item after a write");

endmodule

bind dense_shortest_path_engine_top dspe_checker u_dspe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

### sim/tb_dense_shortest_path_engine_top.sv
module tb_dense_shortest_path_engine_top import dspe_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VERTEX_SLOTS  = 64;
	localparam int SETTLE_CYCLES = 20;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	dspe_item_t   item = '0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [6:0]   cfg_data = '0;
	logic         result_valid;
	dspe_result_t result;

	// predictor state: edge weights and the vertex count in force
	logic [7:0]   weight_mem [VERTEX_SLOTS][VERTEX_SLOTS];
	logic [6:0]   vertex_count_now = VCOUNT_RESET;

	dspe_item_t   pending_items [$];
	dspe_result_t expected_rows [$];
	int           error_count = 0;
	int           burst_left = 0;
	int           gap_left = 0;

	dense_shortest_path_engine_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want,
			logic [5:0] vertex);
		if (got !== want)
			report_mismatch($sformatf("vertex %0d %s got %0h want %0h",
				vertex, name, got, want));
	endtask

	// clamp the register value to the vertices actually in use
	function automatic int vertices_in_use(logic [6:0] count);
		if (count == 0)
			return 1;
		if (count > VERTEX_SLOTS)
			return VERTEX_SLOTS;
		return int'(count);
	endfunction

	// dense Dijkstra from src; queue one expected row per vertex in use
	task automatic solve_paths(logic [5:0] src);
		logic [15:0] path_len [VERTEX_SLOTS];
		logic [5:0]  prev [VERTEX_SLOTS];
		bit          done [VERTEX_SLOTS];
		dspe_result_t row;
		int n, pick, least, sum;
		n = vertices_in_use(vertex_count_now);
		for (int i = 0; i < n; i++) begin
			path_len[i] = UNREACHED;
			prev[i] = '0;
			done[i] = 1'b0;
		end
		if (int'(src) < n) begin
			path_len[src] = '0;
			prev[src] = src;
			while (1) begin
				pick = n;
				least = int'(UNREACHED);
				for (int i = 0; i < n; i++) begin
					if (!done[i] && int'(path_len[i]) < least) begin
						least = int'(path_len[i]);
						pick = i;
					end
				end
				if (pick >= n)
					break;
				done[pick] = 1'b1;
				// relax the row of the vertex just settled
				for (int j = 0; j < n; j++) begin
					if (done[j] || weight_mem[pick][j] == 0)
						continue;
					sum = int'(path_len[pick]) + int'(weight_mem[pick][j]);
					if (sum < int'(UNREACHED) && sum < int'(path_len[j])) begin
						path_len[j] = 16'(sum);
						prev[j] = 6'(pick);
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			row.vertex_index = 6'(i);
			row.reachable    = done[i];
			row.distance     = done[i] ? path_len[i] : UNREACHED;
			row.predecessor  = done[i] ? prev[i] : 6'd0;
			row.last         = (i == n - 1);
			expected_rows = {expected_rows, row};
		end
	endtask

	task automatic apply_item(dspe_item_t it);
		if (it.opcode == OPC_WRITE)
			weight_mem[it.from_vertex][it.to_vertex] = it.edge_weight;
		else
			solve_paths(it.from_vertex);
	endtask

	task automatic push_item(logic op, logic [5:0] a, logic [5:0] b, logic [7:0] w);
		dspe_item_t it;
		it.opcode      = op;
		it.from_vertex = a;
		it.to_vertex   = b;
		it.edge_weight = w;
		pending_items = {pending_items, it};
	endtask

	// mostly edges among the vertices in use, some runs, a few strays
	function automatic dspe_item_t random_item(int n);
		dspe_item_t it;
		int roll, pick;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		it.to_vertex = (pick == 9) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, n - 1));
		if (roll < 25) begin
			it.opcode      = OPC_RUN;
			it.from_vertex = (roll < 4) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, n - 1));
		end else begin
			it.opcode      = OPC_WRITE;
			it.from_vertex = (roll > 92) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, n - 1));
		end
		case (pick)
			0: it.edge_weight = 8'd0;
			1: it.edge_weight = 8'd255;
			2, 3, 4: it.edge_weight = 8'($urandom_range(1, 4));
			default: it.edge_weight = 8'($urandom_range(1, 255));
		endcase
		return it;
	endfunction

	task automatic write_vertex_count(logic [6:0] value);
		@(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		vertex_count_now = value;
		cfg_valid <= 1'b0;
	endtask

	// wait until every item is taken and every row has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || busy || expected_rows.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// drive items in bursts; hold start until the block takes the item
	always @(posedge clk) begin : driver
		bit taken;
		taken = start && !busy;
		if (taken)
			apply_item(item);
		if (arst_n && (taken || !start)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_items.size() != 0) begin
				item  <= pending_items.pop_front();
				start <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 7);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// compare each result row against the oldest expected row
	always @(posedge clk) begin : monitor
		dspe_result_t want;
		if (arst_n && result_valid) begin
			if (expected_rows.size() == 0) begin
				report_mismatch($sformatf("row for vertex %0d with none expected",
					result.vertex_index));
			end else begin
				want = expected_rows.pop_front();
				check_field("vertex_index", 16'(result.vertex_index),
					16'(want.vertex_index), want.vertex_index);
				check_field("reachable", 16'(result.reachable), 16'(want.reachable),
					want.vertex_index);
				check_field("distance", result.distance, want.distance, want.vertex_index);
				check_field("predecessor", 16'(result.predecessor),
					16'(want.predecessor), want.vertex_index);
				check_field("last", 16'(result.last), 16'(want.last), want.vertex_index);
			end
		end
	end

	initial begin : stimulus
		logic [6:0] counts [$];
		int n;
		for (int r = 0; r < VERTEX_SLOTS; r++)
			for (int c = 0; c < VERTEX_SLOTS; c++)
				weight_mem[r][c] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty graph, then a small graph with ties and a self loop
		push_item(OPC_RUN, 6'd0, 6'd0, 8'd0);
		push_item(OPC_WRITE, 6'd0, 6'd1, 8'd1);
		push_item(OPC_WRITE, 6'd0, 6'd2, 8'd5);
		push_item(OPC_WRITE, 6'd1, 6'd2, 8'd3);
		push_item(OPC_WRITE, 6'd2, 6'd3, 8'd2);
		push_item(OPC_WRITE, 6'd1, 6'd3, 8'd5);
		push_item(OPC_WRITE, 6'd3, 6'd3, 8'd7);
		push_item(OPC_WRITE, 6'd3, 6'd63, 8'd255);
		push_item(OPC_WRITE, 6'd63, 6'd0, 8'd1);
		push_item(OPC_RUN, 6'd0, 6'd63, 8'd255);
		// drop an edge, then run from the far end
		push_item(OPC_WRITE, 6'd0, 6'd2, 8'd0);
		push_item(OPC_RUN, 6'd0, 6'd0, 8'd0);
		push_item(OPC_RUN, 6'd63, 6'd0, 8'd0);
		push_item(OPC_WRITE, 6'd21, 6'd42, 8'd170);
		push_item(OPC_WRITE, 6'd42, 6'd21, 8'd85);
		push_item(OPC_RUN, 6'd42, 6'd21, 8'd170);
		push_item(OPC_RUN, 6'd21, 6'd42, 8'd85);
		// equal distances: the lower vertex settles first and sets the path
		push_item(OPC_WRITE, 6'd0, 6'd4, 8'd1);
		push_item(OPC_WRITE, 6'd4, 6'd5, 8'd1);
		push_item(OPC_WRITE, 6'd1, 6'd5, 8'd1);
		push_item(OPC_RUN, 6'd0, 6'd0, 8'd0);
		wait_idle();

		// random phases over several vertex counts, extremes first
		counts = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd2};
		repeat (3) counts = {counts, 7'($urandom_range(3, 12))};
		foreach (counts[p]) begin
			write_vertex_count(counts[p]);
			n = vertices_in_use(counts[p]);
			repeat (15) pending_items = {pending_items, random_item(n)};
			wait_idle();
		end

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/dspe_pkg.sv
hw/rtl/dspe_ctrl.sv
hw/rtl/dspe_datapath.sv
hw/rtl/dense_shortest_path_engine_top.sv
hw/rtl/dspe_checker.sv
sim/tb_dense_shortest_path_engine_top.sv
